// ----- design/rmss_pkg.sv -----
// ----------------------------------------------------------------------------
// rmss_pkg
// Shared types, constants and the node merge for the range max subarray tree.
// ----------------------------------------------------------------------------
package rmss_pkg;

   localparam int MAX_ELEMS_DEF = 4096;
   localparam int CNT_W         = 13;
   localparam int IDX_W         = 12;
   localparam int VAL_W         = 16;
   localparam int SUM_W         = 32;
   localparam int NODE_W        = 4 * SUM_W;

   localparam logic [1:0] ST_UPDATE = 2'd0;
   localparam logic [1:0] ST_QUERY  = 2'd1;
   localparam logic [1:0] ST_ERROR  = 2'd2;

   typedef struct packed {
      logic signed [SUM_W-1:0] tot;
      logic signed [SUM_W-1:0] pre;
      logic signed [SUM_W-1:0] suf;
      logic signed [SUM_W-1:0] run;
   } seg_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_UP_RD, S_UP_WAIT, S_UP_WR,
      S_Q_STEP, S_Q_JOIN, S_Q_FIN, S_OUT
   } state_type;

   function automatic logic signed [SUM_W-1:0] smax(
      input logic signed [SUM_W-1:0] a, input logic signed [SUM_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic seg_type seg_merge(input seg_type a, input seg_type b);
      seg_type c;
      c.tot = a.tot + b.tot;
      c.pre = smax(a.pre, a.tot + b.pre);
      c.suf = smax(b.suf, b.tot + a.suf);
      c.run = smax(smax(a.run, b.run), a.suf + b.pre);
      return c;
   endfunction

endpackage

// ----- design/rmss_ram.sv -----
// ----------------------------------------------------------------------------
// rmss_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rmss_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

// ----- design/range_max_subarray_sum_tree_top.sv -----
// ----------------------------------------------------------------------------
// range_max_subarray_sum_tree_top
// Segment tree of max subarray sums over a signed array, held in one RAM.
//
// Send words on req_*: action 0 writes new_value at index, action 1 asks for
// the best contiguous sum in [range_left, range_right]. Each word yields one
// rsp_* word with best_sum and status (0 update, 1 query, 2 bad range).
// Only one word is in flight; req_ready is high in idle.
// An update writes the leaf, then for each tree level reads both children
// (S_UP_RD, S_UP_WAIT) and writes their merge into the parent (S_UP_WR);
// the next word is taken only after the response is accepted. A query reads
// and joins each covering node (S_Q_STEP, S_Q_JOIN), climbs a level in
// S_Q_STEP when neither bound is odd and finishes in S_Q_FIN. A bad word
// answers the next cycle. The single RAM port serializes these steps.
// After reset a clearing pass zeroes all 2*MAX_ELEMS nodes, one a cycle;
// no word is taken meanwhile, csr writes are.
// The result holds in rsp_* while rsp_ready is low; csr_* writes
// element_count and is always ready.
// ----------------------------------------------------------------------------
module range_max_subarray_sum_tree_top #(
   parameter int MAX_ELEMS = rmss_pkg::MAX_ELEMS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [rmss_pkg::IDX_W-1:0]        req_index,
   input  logic signed [rmss_pkg::VAL_W-1:0] req_new_value,
   input  logic [rmss_pkg::IDX_W-1:0]        req_range_left,
   input  logic [rmss_pkg::IDX_W-1:0]        req_range_right,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [rmss_pkg::SUM_W-1:0] rsp_best_sum,
   output logic [1:0]                        rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rmss_pkg::CNT_W-1:0]        csr_element_count
);

   localparam int AW = $clog2(2 * MAX_ELEMS);
   localparam int DEPTH = 2 * MAX_ELEMS;
   localparam int SUM_W = rmss_pkg::SUM_W;

   rmss_pkg::state_type state_ff, state_in;
   logic [rmss_pkg::CNT_W-1:0] count_ff;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] k_ff, k_in;
   logic [AW:0] lo_ff, lo_in, hi_ff, hi_in;
   logic side_ff, side_in;
   logic hl_ff, hl_in, hr_ff, hr_in;
   rmss_pkg::seg_type la_ff, la_in, ra_ff, ra_in;
   logic signed [SUM_W-1:0] best_ff, best_in;
   logic [1:0] status_ff, status_in;

   logic ram_we;
   logic [AW-1:0] ram_addr;
   logic [rmss_pkg::NODE_W-1:0] ram_wd, ram_rd;
   rmss_pkg::seg_type rd_seg, leaf, joined, fin_seg;

   logic [rmss_pkg::CNT_W:0] limit;
   logic in_fire, upd_ok, qry_ok;
   logic signed [SUM_W-1:0] nv_ext;

   rmss_ram #(.WIDTH(rmss_pkg::NODE_W), .DEPTH(DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wd),
      .rd_data(ram_rd)
   );

   assign rd_seg = rmss_pkg::seg_type'(ram_rd);
   assign nv_ext = SUM_W'(req_new_value);
   assign leaf = '{tot: nv_ext, pre: nv_ext, suf: nv_ext, run: nv_ext};

   always_comb begin
      if (int'(count_ff) < MAX_ELEMS) begin
         limit = {1'b0, count_ff};
      end else begin
         limit = (rmss_pkg::CNT_W+1)'(MAX_ELEMS);
      end
   end

   assign req_ready = (state_ff == rmss_pkg::S_IDLE);
   assign in_fire = req_valid && req_ready;
   assign upd_ok = ((rmss_pkg::CNT_W+1)'(req_index) < limit);
   assign qry_ok = (req_range_left <= req_range_right)
                   && ((rmss_pkg::CNT_W+1)'(req_range_right) < limit);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == rmss_pkg::S_OUT);
   assign rsp_best_sum = best_ff;
   assign rsp_status = status_ff;

   // merge for query: side selects whether the node goes left or right
   always_comb begin
      if (side_ff) begin
         joined = rmss_pkg::seg_merge(rd_seg, ra_ff);
      end else begin
         joined = rmss_pkg::seg_merge(la_ff, rd_seg);
      end
   end

   assign fin_seg = rmss_pkg::seg_merge(la_ff, ra_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rmss_pkg::S_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = rmss_pkg::S_IDLE;
            end
         end
         rmss_pkg::S_IDLE: begin
            if (in_fire) begin
               if (!req_action && upd_ok) begin
                  state_in = rmss_pkg::S_UP_RD;
               end else if (req_action && qry_ok) begin
                  state_in = rmss_pkg::S_Q_STEP;
               end else begin
                  state_in = rmss_pkg::S_OUT;
               end
            end
         end
         rmss_pkg::S_UP_RD: state_in = rmss_pkg::S_UP_WAIT;
         rmss_pkg::S_UP_WAIT: state_in = rmss_pkg::S_UP_WR;
         rmss_pkg::S_UP_WR: begin
            if (k_ff == AW'(1)) begin
               state_in = rmss_pkg::S_OUT;
            end else begin
               state_in = rmss_pkg::S_UP_RD;
            end
         end
         rmss_pkg::S_Q_STEP: begin
            if (lo_ff >= hi_ff) begin
               state_in = rmss_pkg::S_Q_FIN;
            end else if (lo_ff[0] || hi_ff[0]) begin
               state_in = rmss_pkg::S_Q_JOIN;
            end
         end
         rmss_pkg::S_Q_JOIN: state_in = rmss_pkg::S_Q_STEP;
         rmss_pkg::S_Q_FIN: state_in = rmss_pkg::S_OUT;
         rmss_pkg::S_OUT: begin
            if (rsp_ready) begin
               state_in = rmss_pkg::S_IDLE;
            end
         end
         default: state_in = rmss_pkg::S_IDLE;
      endcase
   end

   // datapath: update walks k up; each level reads 2k, 2k+1, writes k
   always_comb begin
      clr_in = clr_ff;
      k_in = k_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      side_in = side_ff;
      hl_in = hl_ff;
      hr_in = hr_ff;
      la_in = la_ff;
      ra_in = ra_ff;
      best_in = best_ff;
      status_in = status_ff;
      ram_we = 1'b0;
      ram_addr = k_ff;
      ram_wd = '0;
      case (state_ff)
         rmss_pkg::S_CLEAR: begin
            ram_we = 1'b1;
            ram_addr = clr_ff;
            ram_wd = '0;
            clr_in = clr_ff + AW'(1);
         end
         rmss_pkg::S_IDLE: begin
            best_in = '0;
            status_in = rmss_pkg::ST_ERROR;
            hl_in = 1'b0;
            hr_in = 1'b0;
            lo_in = (AW+1)'(req_range_left) + (AW+1)'(MAX_ELEMS);
            hi_in = (AW+1)'(req_range_right) + (AW+1)'(MAX_ELEMS) + (AW+1)'(1);
            k_in = AW'(req_index) + AW'(MAX_ELEMS);
            ram_addr = AW'(req_index) + AW'(MAX_ELEMS);
            if (in_fire && !req_action && upd_ok) begin
               ram_we = 1'b1;
               ram_wd = rmss_pkg::NODE_W'(leaf);
               status_in = rmss_pkg::ST_UPDATE;
               k_in = (AW'(req_index) + AW'(MAX_ELEMS)) >> 1;
            end
            if (in_fire && req_action && qry_ok) begin
               status_in = rmss_pkg::ST_QUERY;
            end
         end
         rmss_pkg::S_UP_RD: begin
            ram_addr = {k_ff[AW-2:0], 1'b0};
         end
         rmss_pkg::S_UP_WAIT: begin
            la_in = rd_seg;
            ram_addr = {k_ff[AW-2:0], 1'b1};
         end
         rmss_pkg::S_UP_WR: begin
            side_in = 1'b0;
            ram_we = 1'b1;
            ram_addr = k_ff;
            ram_wd = rmss_pkg::NODE_W'(rmss_pkg::seg_merge(la_ff, rd_seg));
            k_in = k_ff >> 1;
         end
         rmss_pkg::S_Q_STEP: begin
            if (lo_ff < hi_ff) begin
               if (lo_ff[0]) begin
                  ram_addr = lo_ff[AW-1:0];
                  side_in = 1'b0;
                  lo_in = lo_ff + (AW+1)'(1);
               end else if (hi_ff[0]) begin
                  ram_addr = AW'(hi_ff - (AW+1)'(1));
                  side_in = 1'b1;
                  hi_in = hi_ff - (AW+1)'(1);
               end else begin
                  lo_in = lo_ff >> 1;
                  hi_in = hi_ff >> 1;
               end
            end
         end
         rmss_pkg::S_Q_JOIN: begin
            if (!side_ff) begin
               la_in = hl_ff ? joined : rd_seg;
               hl_in = 1'b1;
            end else begin
               ra_in = hr_ff ? joined : rd_seg;
               hr_in = 1'b1;
            end
         end
         rmss_pkg::S_Q_FIN: begin
            if (hl_ff && hr_ff) begin
               best_in = fin_seg.run;
            end else if (hr_ff) begin
               best_in = ra_ff.run;
            end else begin
               best_in = la_ff.run;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmss_pkg::S_CLEAR;
         count_ff <= rmss_pkg::CNT_W'(4096);
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_element_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      side_ff <= side_in;
      hl_ff <= hl_in;
      hr_ff <= hr_in;
      la_ff <= la_in;
      ra_ff <= ra_in;
      best_ff <= best_in;
      status_ff <= status_in;
   end

endmodule
